// File: sv/mtet_pkg.sv
package mtet_pkg;

    localparam int unsigned W = 32;

    typedef struct packed {
        logic signed [W-1:0] x;
        logic signed [W-1:0] y;
        logic signed [W-1:0] z;
        logic signed [W-1:0] scalar;
        logic signed [W-1:0] attr;
    } t_vertex;

    typedef struct packed {
        logic signed [W-1:0] x;
        logic signed [W-1:0] y;
        logic signed [W-1:0] z;
        logic signed [W-1:0] attr;
        logic                triangle_end;
        logic                element_end;
    } t_point;

    localparam logic [1:0] TRI_CNT [16] = '{
        2'd0, 2'd1, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2, 2'd1,
        2'd1, 2'd2, 2'd2, 2'd1, 2'd2, 2'd1, 2'd1, 2'd0};
    localparam logic [1:0] TRI_REV [16] = '{
        2'd0, 2'd0, 2'd0, 2'd1, 2'd0, 2'd0, 2'd2, 2'd1,
        2'd0, 2'd1, 2'd3, 2'd1, 2'd2, 2'd1, 2'd1, 2'd0};

    function automatic logic [3:0] tri_edge(input logic [3:0] code, input logic [2:0] k);
        logic [23:0] row;
        case (code)
            4'h1, 4'hE: row = {4'h0, 4'h0, 4'h0, 4'h3, 4'h2, 4'h1};
            4'h2, 4'hD: row = {4'h0, 4'h0, 4'h0, 4'h6, 4'h7, 4'h4};
            4'h3, 4'hC: row = {4'h2, 4'h6, 4'h7, 4'h7, 4'h2, 4'h3};
            4'h4, 4'hB: row = {4'h0, 4'h0, 4'h0, 4'hB, 4'h9, 4'h8};
            4'h5, 4'hA: row = {4'hB, 4'h6, 4'h1, 4'h3, 4'hB, 4'h1};
            4'h6, 4'h9: row = {4'hB, 4'h2, 4'h1, 4'hB, 4'h7, 4'h1};
            4'h7, 4'h8: row = {4'h0, 4'h0, 4'h0, 4'hD, 4'hE, 4'hC};
            default:    row = '0;
        endcase
        tri_edge = row[k*4 +: 4];
    endfunction

endpackage

// File: sv/mtet_if.sv
interface mtet_vtx_if;
    logic              valid;
    logic              ready;
    mtet_pkg::t_vertex data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mtet_pt_if;
    logic             valid;
    logic             ready;
    mtet_pkg::t_point data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: sv/marching_tetra_isosurface_top.sv
// Vertices 0..2 are only stored; the fourth starts 0, 3 or 6 points, each through one setup
// state, a shared restoring divider, one shared 32x31 multiplier for all four
// components and one output state that waits for a free output register.
// Throughput: one vertex a cycle while loading; input held off until the last point is
// in the output register and setup ends the cell (an empty cell passes setup only).
// Reset (i_rst_n, sync, active low) clears iso_value, the vertex count and control.
module marching_tetra_isosurface_top (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [mtet_pkg::W-1:0] i_cfg_data,
    mtet_vtx_if.sink               i_vtx,
    mtet_pt_if.source              o_pt
);

    typedef enum logic [2:0] {S_LOAD, S_SETUP, S_DIV, S_MUL, S_OUT} t_state;

    t_state r_state;
    logic signed [31:0] r_iso;
    mtet_pkg::t_vertex r_v [4];
    logic [1:0]  r_cnt;
    logic [3:0]  r_code;
    logic [2:0]  r_pt;
    logic [1:0]  r_a, r_b;
    logic [32:0] r_rem;
    logic [32:0] r_den;
    logic [30:0] r_q;
    logic [4:0]  r_bit;
    logic [2:0]  r_comp;
    logic signed [31:0] r_res [4];
    logic        r_zero;
    logic        r_valid;
    mtet_pkg::t_point r_out;

    logic [2:0] n_tot;
    logic       n_tri;
    logic [1:0] n_c;
    logic       n_rev;
    logic [3:0] n_e;
    logic signed [32:0] n_num, n_dnm;
    logic [32:0] n_dvd;
    logic [33:0] n_trial;
    logic signed [31:0] n_va, n_vb;
    logic signed [32:0] n_d;
    logic [32:0] n_mag;
    logic [63:0] n_prod;
    logic [33:0] n_off;
    logic [3:0]  n_code;
    logic [31:0] n_t;

    assign i_vtx.ready = (r_state == S_LOAD);
    assign o_pt.valid  = r_valid;
    assign o_pt.data   = r_out;

    always_comb begin
        n_tot = {1'b0, mtet_pkg::TRI_CNT[r_code]} * 3'd3;
        n_tri = (r_pt >= 3'd3);
        n_c   = n_tri ? 2'(r_pt - 3'd3) : r_pt[1:0];
        n_rev = mtet_pkg::TRI_REV[r_code][n_tri];
        n_e   = mtet_pkg::tri_edge(r_code,
                3'({2'b0, n_tri} * 3'd3 + {1'b0, (n_rev ? 2'(2'd2 - n_c) : n_c)}));
        n_num = 33'(r_iso) - 33'(r_v[n_e[3:2]].scalar);
        n_dnm = 33'(r_v[n_e[1:0]].scalar) - 33'(r_v[n_e[3:2]].scalar);
        // first step compares num with den unshifted (quotient bit 30)
        n_dvd = (r_bit == 5'd0) ? r_rem : {r_rem[31:0], 1'b0};
        n_trial = {1'b0, n_dvd} - {1'b0, r_den};
        case (r_comp)
            3'd0:    begin n_va = r_v[r_a].x; n_vb = r_v[r_b].x; end
            3'd1:    begin n_va = r_v[r_a].y; n_vb = r_v[r_b].y; end
            3'd2:    begin n_va = r_v[r_a].z; n_vb = r_v[r_b].z; end
            default: begin n_va = r_v[r_a].attr; n_vb = r_v[r_b].attr; end
        endcase
        n_d   = 33'(n_vb) - 33'(n_va);
        n_mag = n_d[32] ? 33'(-n_d) : n_d;
        // quotient saturates at 2^30 (r_q[30] set means >= 2^30)
        n_t   = r_zero ? 32'd0 : (r_q[30] ? 32'h4000_0000 : {2'b0, r_q[29:0]});
        n_prod = n_mag[31:0] * n_t;
        n_off = 34'((n_prod + 64'h2000_0000) >> 30);
        for (int i = 0; i < 4; i++) begin
            n_code[i] = r_v[i].scalar < r_iso;
        end
        if (r_cnt == 2'd3) begin
            n_code[3] = i_vtx.data.scalar < r_iso;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_iso   <= '0;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_iso <= i_cfg_data;
            end
            case (r_state)
                S_LOAD: begin
                    if (i_vtx.valid) begin
                        r_v[r_cnt] <= i_vtx.data;
                        r_cnt <= 2'(r_cnt + 2'd1);
                        if (r_cnt == 2'd3) begin
                            r_code  <= n_code;
                            r_pt    <= '0;
                            r_state <= S_SETUP;
                        end
                    end
                end
                S_SETUP: begin
                    if (r_pt == n_tot) begin
                        r_state <= S_LOAD;
                    end else begin
                        r_a    <= n_e[3:2];
                        r_b    <= n_e[1:0];
                        r_rem  <= n_num[32] ? 33'(-n_num) : n_num;
                        r_den  <= n_dnm[32] ? 33'(-n_dnm) : n_dnm;
                        r_zero <= (n_dnm == 0) || (n_num == 0) || (n_num[32] != n_dnm[32]);
                        r_q    <= '0;
                        r_bit  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    // 31 steps give floor(num*2^30/den); num >= den saturates via bit 30
                    if (!n_trial[33]) begin
                        r_rem <= n_trial[32:0];
                        r_q   <= {r_q[29:0], 1'b1};
                    end else begin
                        r_rem <= n_dvd;
                        r_q   <= {r_q[29:0], 1'b0};
                    end
                    r_bit <= 5'(r_bit + 5'd1);
                    if (r_bit == 5'd30) begin
                        r_comp  <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_res[r_comp[1:0]] <= n_d[32] ? 32'(n_va - 32'(n_off))
                                                  : 32'(n_va + 32'(n_off));
                    r_comp <= 3'(r_comp + 3'd1);
                    if (r_comp == 3'd3) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_valid) begin
                        r_out.x <= r_res[0];
                        r_out.y <= r_res[1];
                        r_out.z <= r_res[2];
                        r_out.attr <= r_res[3];
                        r_out.triangle_end <= (r_pt == 3'd2) || (r_pt == 3'd5);
                        r_out.element_end  <= (3'(r_pt + 3'd1) == n_tot);
                        r_valid <= 1'b1;
                        r_pt    <= 3'(r_pt + 3'd1);
                        r_state <= S_SETUP;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
            if (r_valid && o_pt.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

`ifndef ASSERT_OFF
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD) |-> !i_vtx.ready) else $error("ready while busy");
    a_pt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SETUP) |-> (r_pt <= n_tot)) else $error("point count overrun");
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_bit <= 5'd30)) else $error("divider overrun");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !o_pt.ready) |=> r_valid) else $error("item dropped");
`endif

endmodule

// File: bench/mtet_scoreboard.sv
module mtet_scoreboard (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [mtet_pkg::W-1:0] i_cfg_data,
    mtet_vtx_if                    i_vtx,
    mtet_pt_if                     i_pt,
    output int                     o_fail_count,
    output int                     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned ONE_T = 64'd1 << 30;
    localparam longint unsigned HALF_T = 64'd1 << 29;

    // triangles per code, per-triangle corner-order reversal mask, edge list as (a << 2) | b
    localparam int TRI_TOTAL [16] = '{0, 1, 1, 2, 1, 2, 2, 1, 1, 2, 2, 1, 2, 1, 1, 0};
    localparam int TRI_FLIP  [16] = '{0, 0, 0, 1, 0, 0, 2, 1, 0, 1, 3, 1, 2, 1, 1, 0};
    localparam int EDGES [16][6] = '{
        '{0, 0, 0, 0, 0, 0},
        '{1, 2, 3, 0, 0, 0},
        '{4, 7, 6, 0, 0, 0},
        '{3, 2, 7, 7, 6, 2},
        '{8, 9, 11, 0, 0, 0},
        '{1, 11, 3, 1, 6, 11},
        '{1, 7, 11, 1, 2, 11},
        '{12, 14, 13, 0, 0, 0},
        '{12, 14, 13, 0, 0, 0},
        '{1, 7, 11, 1, 2, 11},
        '{1, 11, 3, 1, 6, 11},
        '{8, 9, 11, 0, 0, 0},
        '{3, 2, 7, 7, 6, 2},
        '{4, 7, 6, 0, 0, 0},
        '{1, 2, 3, 0, 0, 0},
        '{0, 0, 0, 0, 0, 0}
    };

    logic signed [mtet_pkg::W-1:0] iso_level;
    mtet_pkg::t_vertex             corner [4];
    int                            loaded;
    mtet_pkg::t_point              point_q [$];
    int                            fails;

    assign o_fail_count = fails;
    assign o_pending = point_q.size();

    function automatic longint unsigned magnitude(input longint v);
        magnitude = (v < 0) ? longint'(-v) : v;
    endfunction

    function automatic logic [mtet_pkg::W-1:0] blend(
            input logic signed [mtet_pkg::W-1:0] va,
            input logic signed [mtet_pkg::W-1:0] vb,
            input longint unsigned t);
        longint          a;
        longint          d;
        longint unsigned off;
        a = va;
        d = longint'(vb) - a;
        off = (magnitude(d) * t + HALF_T) >> 30;
        blend = (d >= 0) ? mtet_pkg::W'(a + longint'(off))
                         : mtet_pkg::W'(a - longint'(off));
    endfunction

    function automatic mtet_pkg::t_point edge_point(input int a, input int b);
        longint           num;
        longint           den;
        longint unsigned  t;
        mtet_pkg::t_point p;
        num = longint'(iso_level) - longint'(corner[a].scalar);
        den = longint'(corner[b].scalar) - longint'(corner[a].scalar);
        t = 0;
        if (den != 0 && num != 0 && ((num < 0) == (den < 0))) begin
            t = (magnitude(num) << 30) / magnitude(den);
            if (t > ONE_T) t = ONE_T;
        end
        p.x = blend(corner[a].x, corner[b].x, t);
        p.y = blend(corner[a].y, corner[b].y, t);
        p.z = blend(corner[a].z, corner[b].z, t);
        p.attr = blend(corner[a].attr, corner[b].attr, t);
        p.triangle_end = 1'b0;
        p.element_end = 1'b0;
        return p;
    endfunction

    task automatic predict_surface();
        int               code;
        int               idx;
        int               e;
        int               made;
        bit               flip;
        mtet_pkg::t_point p;
        code = 0;
        made = 0;
        for (int c = 0; c < 4; c++) begin
            if (corner[c].scalar < iso_level) code |= 1 << c;
        end
        for (int tn = 0; tn < TRI_TOTAL[code]; tn++) begin
            flip = ((TRI_FLIP[code] >> tn) & 1) != 0;
            for (int c = 0; c < 3; c++) begin
                idx = flip ? 2 - c : c;
                e = EDGES[code][tn * 3 + idx];
                p = edge_point((e >> 2) & 3, e & 3);
                p.triangle_end = (c == 2);
                point_q.push_back(p);
                made++;
            end
        end
        if (made > 0) point_q[point_q.size() - 1].element_end = 1'b1;
    endtask

    always @(posedge i_clk) begin
        mtet_pkg::t_point want;
        if (!i_rst_n) begin
            iso_level <= '0;
            loaded = 0;
        end else begin
            if (i_cfg_we) iso_level <= i_cfg_data;
            if (i_vtx.valid && i_vtx.ready) begin
                corner[loaded] = i_vtx.data;
                if (loaded == 3) begin
                    loaded = 0;
                    predict_surface();
                end else begin
                    loaded++;
                end
            end
            if (i_pt.valid && i_pt.ready) begin
                if (point_q.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("unexpected point %h", i_pt.data);
                end else begin
                    want = point_q.pop_front();
                    if (want.x !== i_pt.data.x || want.y !== i_pt.data.y ||
                        want.z !== i_pt.data.z || want.attr !== i_pt.data.attr ||
                        want.triangle_end !== i_pt.data.triangle_end ||
                        want.element_end !== i_pt.data.element_end) begin
                        fails++;
                        if (fails <= 10)
                            $display("point mismatch: exp %h %h %h %h %b%b got %h %h %h %h %b%b",
                                     want.x, want.y, want.z, want.attr,
                                     want.triangle_end, want.element_end,
                                     i_pt.data.x, i_pt.data.y, i_pt.data.z,
                                     i_pt.data.attr, i_pt.data.triangle_end,
                                     i_pt.data.element_end);
                    end
                end
            end
        end
    end

    initial begin
        fails = 0;
        loaded = 0;
    end

endmodule

// File: bench/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_WAIT = 300;
    localparam int HOLD_CYCLES = 500;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [mtet_pkg::W-1:0] i_cfg_data;
    int                     fail_count;
    int                     pending;
    int                     quiet_cycles;
    bit                     no_idle;
    bit                     hold_req;
    int                     sent;

    mtet_vtx_if vtx ();
    mtet_pt_if  pt ();

    marching_tetra_isosurface_top DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_vtx     (vtx.sink),
        .o_pt      (pt.source)
    );

    mtet_scoreboard u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_vtx       (vtx),
        .i_pt        (pt),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if ((vtx.valid && vtx.ready) || (pt.valid && pt.ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // point receiver
    initial begin
        int gap;
        pt.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_req) begin
                pt.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            gap = no_idle ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                pt.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pt.ready <= 1'b1;
            do @(posedge i_clk); while (!pt.valid);
        end
    end

    function automatic logic [mtet_pkg::W-1:0] pick_coord();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [mtet_pkg::W-1:0] pick_scalar(
            input logic [mtet_pkg::W-1:0] iso);
        case ($urandom_range(0, 5))
            0: return iso;
            1, 2: return iso + mtet_pkg::W'($urandom_range(0, 10)) - mtet_pkg::W'(5);
            3: return iso + mtet_pkg::W'($urandom_range(0, 1 << 20))
                          - mtet_pkg::W'(1 << 19);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_vertex(input logic [mtet_pkg::W-1:0] s);
        mtet_pkg::t_vertex v;
        int                gap;
        v.x = pick_coord();
        v.y = pick_coord();
        v.z = pick_coord();
        v.scalar = s;
        v.attr = pick_coord();
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            vtx.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        vtx.valid <= 1'b1;
        vtx.data <= v;
        do @(posedge i_clk); while (!vtx.ready);
        sent++;
    endtask

    task automatic send_tet(input logic [mtet_pkg::W-1:0] s0,
                            input logic [mtet_pkg::W-1:0] s1,
                            input logic [mtet_pkg::W-1:0] s2,
                            input logic [mtet_pkg::W-1:0] s3);
        send_vertex(s0);
        send_vertex(s1);
        send_vertex(s2);
        send_vertex(s3);
    endtask

    task automatic set_iso(input logic [mtet_pkg::W-1:0] level);
        vtx.valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= level;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [mtet_pkg::W-1:0] iso_list [8];
        logic [mtet_pkg::W-1:0] iso;
        vtx.valid = 1'b0;
        vtx.data = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        quiet_cycles = 0;
        no_idle = 1'b0;
        hold_req = 1'b0;
        sent = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, iso at reset value
        send_tet(32'd0, 32'd0, 32'd0, 32'd0);
        send_tet(-32'sd1, -32'sd7, 32'h8000_0000, -32'sd2);
        send_tet(-32'sd1, 32'd5, 32'd5, 32'h7FFF_FFFF);
        send_tet(-32'sd3, -32'sd3, 32'd4, 32'd4);
        send_tet(32'd7, -32'sd2, -32'sd9, 32'd1);
        send_tet(32'd0, 32'h8000_0000, 32'h7FFF_FFFF, -32'sd1);

        iso_list = '{32'h7FFF_FFFF, 32'h8000_0000, 32'd0, $urandom, $urandom,
                     32'h0001_0000, $urandom, 32'hFFFF_0000};
        foreach (iso_list[ph]) begin
            iso = iso_list[ph];
            set_iso(iso);
            no_idle = (ph == 3);
            if (ph == 2) hold_req = 1'b1;
            for (int n = 0; n < 3; n++) begin
                if (ph == 5 && n == 2) begin
                    vtx.valid <= 1'b0;
                    @(posedge i_clk);
                    wait (pending == 0);
                end
                send_tet(pick_scalar(iso), pick_scalar(iso), pick_scalar(iso),
                         pick_scalar(iso));
            end
        end
        no_idle = 1'b0;
        while (sent < 124)
            send_tet(pick_scalar(iso), pick_scalar(iso), pick_scalar(iso), pick_scalar(iso));
        vtx.valid <= 1'b0;

        wait (pending == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
